// ----- design/lcai_pkg.sv -----
// shared types, constants and the divider step for the line clipper
`timescale 1ns / 1ps

package lcai_pkg;

   // fixed point layout
   localparam int FRAC_BITS  = 16;
   localparam int COORD_FRAC = 16;
   localparam int T_W        = FRAC_BITS + 1;
   localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;
   localparam logic [T_W-1:0] T_OVF = T_ONE + T_W'(1);

   // counts
   localparam int NUM_AXES = 3;
   localparam int NUM_ATTR = 6;
   localparam int NUM_BND  = 6;

   // operand widths
   localparam int RES_W  = 13;
   localparam int FAR_W  = 31;
   localparam int HN_W   = 34;
   localparam int DEN_W  = 33;
   localparam int REM_W  = 35;
   localparam int PROD_W = DEN_W + T_W + 1;
   localparam int SUM_W  = PROD_W + 1;
   localparam logic signed [HN_W-1:0] COORD_ONE = HN_W'(1) << COORD_FRAC;

   // divider pipeline: one load stage and one stage per quotient bit
   localparam int NSTG = FRAC_BITS + 2;

   // queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;
   localparam int CNT_W      = FIFO_AW + 1;

   // register reset values
   localparam logic [RES_W-1:0] HOR_RESET = 13'd640;
   localparam logic [RES_W-1:0] VER_RESET = 13'd480;
   localparam logic [FAR_W-1:0] FAR_RESET = 31'd65536000;

   typedef enum logic [1:0] {
      CSR_HOR = 2'd0,
      CSR_VER = 2'd1,
      CSR_FAR = 2'd2
   } csr_idx_type;

   // what a boundary does to the segment, settled in the front
   typedef enum logic [1:0] {
      CLS_PASS,
      CLS_REJ,
      CLS_DIV
   } bnd_cls_type;

   typedef struct packed {
      bnd_cls_type      cls;
      logic             enter;
      logic [REM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [T_W-1:0]   quo;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      logic signed [31:0] p0;
      logic signed [32:0] dlt;
   } attr_type;

   typedef struct packed {
      lane_type [NUM_BND-1:0]  lane;
      attr_type [NUM_ATTR-1:0] attr;
   } seg_type;

   // one restoring division step; the first step also flags a quotient >= 2.0
   function automatic lane_type lane_step(input lane_type l, input logic first);
      lane_type         o;
      logic [REM_W-1:0] r;
      logic             ge;
      o  = l;
      r  = first ? l.rem : {l.rem[REM_W-2:0], 1'b0};
      ge = r >= {2'b00, l.den};
      if (first) o.ovf = l.rem >= {1'b0, l.den, 1'b0};
      o.rem = ge ? r - {2'b00, l.den} : r;
      o.quo = {l.quo[T_W-2:0], ge};
      return o;
   endfunction

endpackage

// ----- design/lcai_front.sv -----
// front end: takes a segment, forms deltas and boundary numerators, classifies boundaries
`timescale 1ns / 1ps

module lcai_front import lcai_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [NUM_AXES-1:0][31:0]     pos_start,
   input  logic [NUM_AXES-1:0][31:0]     pos_end,
   input  logic [NUM_AXES-1:0][15:0]     col_start,
   input  logic [NUM_AXES-1:0][15:0]     col_end,
   input  logic [RES_W-1:0]              hor_res,
   input  logic [RES_W-1:0]              ver_res,
   input  logic [FAR_W-1:0]              far_dist,
   output logic                          seg_valid,
   output seg_type                       seg
);

   logic                  fv_ff;
   attr_type              attr_in [NUM_ATTR];
   attr_type              attr_ff [NUM_ATTR];
   logic signed [HN_W-1:0] hn_in  [NUM_AXES];
   logic signed [HN_W-1:0] hn_ff  [NUM_AXES];
   logic signed [HN_W-1:0] lim    [NUM_AXES];

   // clip limits in signed Q18.16
   always_comb begin
      lim[0] = $signed({{(HN_W-RES_W-COORD_FRAC){1'b0}}, hor_res, {COORD_FRAC{1'b0}}})
               - COORD_ONE;
      lim[1] = $signed({{(HN_W-RES_W-COORD_FRAC){1'b0}}, ver_res, {COORD_FRAC{1'b0}}})
               - COORD_ONE;
      lim[2] = $signed({{(HN_W-FAR_W){1'b0}}, far_dist}) - COORD_ONE;
   end

   // deltas and distance past the upper limits
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         attr_in[i].p0  = pos_start[i];
         attr_in[i].dlt = $signed({pos_end[i][31], pos_end[i]})
                          - $signed({pos_start[i][31], pos_start[i]});
         hn_in[i]       = $signed({{2{pos_start[i][31]}}, pos_start[i]}) - lim[i];
         attr_in[NUM_AXES+i].p0  = {16'b0, col_start[i]};
         attr_in[NUM_AXES+i].dlt = $signed({17'b0, col_end[i]}) - $signed({17'b0, col_start[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         attr_ff <= attr_in;
         hn_ff   <= hn_in;
      end
   end

   // boundary classification: lower plane then upper plane per axis
   always_comb begin
      logic signed [31:0]     p0;
      logic signed [32:0]     d;
      logic signed [HN_W-1:0] p0e;
      logic signed [HN_W-1:0] np0;
      logic signed [HN_W-1:0] hn;
      logic signed [HN_W-1:0] nhn;
      logic [DEN_W-1:0]       ad;
      logic                   dz;
      logic                   dn;
      lane_type               lo;
      lane_type               hi;
      for (int i = 0; i < NUM_ATTR; i++) seg.attr[i] = attr_ff[i];
      for (int i = 0; i < NUM_AXES; i++) begin
         p0  = attr_ff[i].p0;
         d   = attr_ff[i].dlt;
         p0e = $signed({{(HN_W-32){p0[31]}}, p0});
         np0 = -p0e;
         hn  = hn_ff[i];
         nhn = -hn;
         dz  = d == 33'sd0;
         dn  = d[32];
         ad  = dn ? -d : d;
         lo  = '{cls: CLS_PASS, enter: 1'b0, rem: '0, den: ad, quo: '0, ovf: 1'b0};
         hi  = lo;
         if (dz) begin
            lo.cls = (p0e < 0) ? CLS_REJ : CLS_PASS;
         end else if (!dn) begin
            if (p0e <= 0) begin
               lo.cls   = CLS_DIV;
               lo.enter = 1'b1;
               lo.rem   = {2'b00, np0[DEN_W-1:0]};
            end
         end else begin
            if (p0e < 0) begin
               lo.cls = CLS_REJ;
            end else begin
               lo.cls = CLS_DIV;
               lo.rem = {2'b00, p0e[DEN_W-1:0]};
            end
         end
         if (dz) begin
            hi.cls = (hn > 0) ? CLS_REJ : CLS_PASS;
         end else if (dn) begin
            if (hn >= 0) begin
               hi.cls   = CLS_DIV;
               hi.enter = 1'b1;
               hi.rem   = {2'b00, hn[DEN_W-1:0]};
            end
         end else begin
            if (hn > 0) begin
               hi.cls = CLS_REJ;
            end else begin
               hi.cls = CLS_DIV;
               hi.rem = {2'b00, nhn[DEN_W-1:0]};
            end
         end
         seg.lane[2*i]   = lo;
         seg.lane[2*i+1] = hi;
      end
   end

   assign seg_valid = fv_ff;

endmodule

// ----- design/lcai_fifo.sv -----
// short queue of classified segments between front and back
`timescale 1ns / 1ps

module lcai_fifo import lcai_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  seg_type          push_data,
   input  logic             pop,
   output seg_type          pop_data,
   output logic [CNT_W-1:0] count
);

   seg_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff;
   logic [FIFO_AW-1:0] rd_ptr_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;

   // occupancy
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + CNT_W'(1);
      if (!push && pop) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         if (pop)  rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign count    = cnt_ff;

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> cnt_ff < CNT_W'(FIFO_DEPTH))
      else $error("segment queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0)
      else $error("segment queue underflow");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && pop |=> $stable(cnt_ff))
      else $error("queue count moved on a simultaneous push and pop");
`endif

endmodule

// ----- design/lcai_back.sv -----
// back end: pipelined boundary dividers, parameter fold, interpolation and result sequencing
`timescale 1ns / 1ps

module lcai_back import lcai_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  seg_type                      head,
   output logic                         pop,
   output logic                         rsp_valid,
   output logic                         rsp_visible,
   output logic                         rsp_last,
   output logic [NUM_ATTR-1:0][31:0]    rsp_point
);

   logic                    adv;
   seg_type                 pipe_ff [NSTG];
   seg_type                 pipe_in [NSTG];
   logic [NSTG-1:0]         pv_ff;

   logic                    fold_v_ff;
   logic                    fold_ok_in;
   logic                    fold_ok_ff;
   logic [T_W-1:0]          te_in;
   logic [T_W-1:0]          tl_in;
   logic [T_W-1:0]          te_ff;
   logic [T_W-1:0]          tl_ff;
   attr_type                fold_attr_ff [NUM_ATTR];

   logic                    mul_v_ff;
   logic                    mul_ok_ff;
   logic signed [PROD_W-1:0] pa_in [NUM_ATTR];
   logic signed [PROD_W-1:0] pb_in [NUM_ATTR];
   logic signed [PROD_W-1:0] pa_ff [NUM_ATTR];
   logic signed [PROD_W-1:0] pb_ff [NUM_ATTR];
   logic [31:0]             mp0_ff [NUM_ATTR];

   logic                    fin_v_ff;
   logic                    fin_ok_ff;
   logic [NUM_ATTR-1:0][31:0] ra_in;
   logic [NUM_ATTR-1:0][31:0] rb_in;
   logic [NUM_ATTR-1:0][31:0] ra_ff;
   logic [NUM_ATTR-1:0][31:0] rb_ff;

   logic                    pend_ff;
   logic [NUM_ATTR-1:0][31:0] sec_ff;
   logic                    out_valid_ff;
   logic                    out_vis_ff;
   logic                    out_last_ff;
   logic [NUM_ATTR-1:0][31:0] out_pt_ff;

   // the divider, fold, multiply and sum stages hold while the second point of a pair goes out
   assign adv = !pend_ff;
   assign pop = head_valid && adv;

   // divider stages
   always_comb begin
      pipe_in[0] = head;
      for (int s = 1; s < NSTG; s++) begin
         pipe_in[s] = pipe_ff[s-1];
         for (int b = 0; b < NUM_BND; b++) begin
            pipe_in[s].lane[b] = lane_step(pipe_ff[s-1].lane[b], s == 1);
         end
      end
   end

   // fold the six crossings into entering and leaving parameters
   always_comb begin
      lane_type       l;
      logic [T_W-1:0] t;
      te_in      = '0;
      tl_in      = T_ONE;
      fold_ok_in = 1'b1;
      for (int b = 0; b < NUM_BND; b++) begin
         l = pipe_ff[NSTG-1].lane[b];
         t = l.ovf ? T_OVF : l.quo;
         if (fold_ok_in) begin
            case (l.cls)
               CLS_REJ: fold_ok_in = 1'b0;
               CLS_DIV: begin
                  if (l.enter) begin
                     if (t > tl_in) fold_ok_in = 1'b0;
                     else if (t > te_in) te_in = t;
                  end else begin
                     if (t < te_in) fold_ok_in = 1'b0;
                     else if (t < tl_in) tl_in = t;
                  end
               end
               default: ;
            endcase
         end
      end
   end

   // delta times parameter
   always_comb begin
      for (int a = 0; a < NUM_ATTR; a++) begin
         pa_in[a] = $signed(fold_attr_ff[a].dlt) * $signed({1'b0, te_ff});
         pb_in[a] = $signed(fold_attr_ff[a].dlt) * $signed({1'b0, tl_ff});
      end
   end

   // start value plus rounded product
   always_comb begin
      logic [SUM_W-1:0] base;
      logic [SUM_W-1:0] sa;
      logic [SUM_W-1:0] sb;
      for (int a = 0; a < NUM_ATTR; a++) begin
         base = {{(SUM_W-32-FRAC_BITS){mp0_ff[a][31]}}, mp0_ff[a], {FRAC_BITS{1'b0}}}
                + (SUM_W'(1) << (FRAC_BITS - 1));
         sa   = base + {pa_ff[a][PROD_W-1], pa_ff[a]};
         sb   = base + {pb_ff[a][PROD_W-1], pb_ff[a]};
         ra_in[a] = sa[FRAC_BITS +: 32];
         rb_in[a] = sb[FRAC_BITS +: 32];
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff     <= '0;
         fold_v_ff <= 1'b0;
         mul_v_ff  <= 1'b0;
         fin_v_ff  <= 1'b0;
      end else if (adv) begin
         pv_ff     <= {pv_ff[NSTG-2:0], pop};
         fold_v_ff <= pv_ff[NSTG-1];
         mul_v_ff  <= fold_v_ff;
         fin_v_ff  <= mul_v_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff    <= pipe_in;
         fold_ok_ff <= fold_ok_in;
         te_ff      <= te_in;
         tl_ff      <= tl_in;
         for (int a = 0; a < NUM_ATTR; a++) begin
            fold_attr_ff[a] <= pipe_ff[NSTG-1].attr[a];
            mp0_ff[a]       <= fold_attr_ff[a].p0;
         end
         mul_ok_ff <= fold_ok_ff;
         pa_ff     <= pa_in;
         pb_ff     <= pb_in;
         fin_ok_ff <= mul_ok_ff;
         ra_ff     <= ra_in;
         rb_ff     <= rb_in;
      end
   end

   // result sequencing: clipped start, then clipped end in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         out_vis_ff   <= 1'b0;
         out_last_ff  <= 1'b0;
      end else if (pend_ff) begin
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b1;
         out_vis_ff   <= 1'b1;
         out_last_ff  <= 1'b1;
      end else begin
         pend_ff      <= fin_v_ff && fin_ok_ff;
         out_valid_ff <= fin_v_ff;
         out_vis_ff   <= fin_ok_ff;
         out_last_ff  <= !fin_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         out_pt_ff <= sec_ff;
      end else begin
         out_pt_ff <= fin_ok_ff ? ra_ff : '0;
         sec_ff    <= rb_ff;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_visible = out_vis_ff;
   assign rsp_last    = out_last_ff;
   assign rsp_point   = out_pt_ff;

`ifndef NO_ASSERTIONS
   a_pend_after_first: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> out_valid_ff && out_vis_ff && !out_last_ff)
      else $error("pending second point without a first point on the port");
   a_reject_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_vis_ff |-> out_last_ff && out_pt_ff == '0)
      else $error("rejected segment result malformed");
   a_pair_completes: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_vis_ff && !out_last_ff |=> out_valid_ff && out_vis_ff && out_last_ff)
      else $error("clipped start not followed by clipped end");
   a_no_pop_in_hold: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> $stable(pv_ff))
      else $error("pipeline moved while the result pair was going out");
`endif

endmodule

// ----- design/line_clip_with_attribute_interp.sv -----
// top level of the 3d line clipper with color interpolation
`timescale 1ns / 1ps

// Clips a 3d segment with an rgb color per end against the box
// x in 0..hor-1, y in 0..ver-1, z in 0..far-1 (Liang-Barsky).
// Input: a segment transfer happens on a clock edge with start high and
// busy low. Output: each result is on the rsp_ ports for one cycle with
// rsp_valid high; the receiver cannot stall, so results are never held.
// A rejected segment gives one result (visible 0, last_item 1, points 0);
// a kept segment gives the clipped start and then the clipped end on the
// next cycle (last_item on the second).
// A segment passes the front end register, the queue, the divider and the
// fold, multiply, sum and output registers; the six boundary divisions run
// in an 18-stage pipelined divider (one load stage and 17 quotient steps).
// Throughput: one segment per cycle while segments are rejected; a kept one
// holds the back end while its second point goes out (single result port).
// A 4-entry queue between the classifying front end and divider back end
// absorbs the difference; busy rises when queue and front end hold 4.
// Registers must be written through csr_ only while idle; the block does
// not enforce it, and csr_ready is always high. Synchronous reset empties
// the pipeline and queue and restores hor 640, ver 480, far 1000.0.

module line_clip_with_attribute_interp import lcai_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic [15:0]        req_start_red,
   input  logic [15:0]        req_start_green,
   input  logic [15:0]        req_start_blue,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic signed [31:0] req_end_z,
   input  logic [15:0]        req_end_red,
   input  logic [15:0]        req_end_green,
   input  logic [15:0]        req_end_blue,
   output logic               rsp_valid,
   output logic               rsp_visible,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   output logic [15:0]        rsp_point_red,
   output logic [15:0]        rsp_point_green,
   output logic [15:0]        rsp_point_blue,
   output logic               rsp_last_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_data
);

   logic [RES_W-1:0]          hor_ff;
   logic [RES_W-1:0]          ver_ff;
   logic [FAR_W-1:0]          far_ff;
   logic                      accept;
   logic                      seg_valid;
   seg_type                   seg;
   seg_type                   head;
   logic [CNT_W-1:0]          fifo_cnt;
   logic                      pop;
   logic [NUM_ATTR-1:0][31:0] point;
   logic [NUM_AXES-1:0][31:0] pos_start;
   logic [NUM_AXES-1:0][31:0] pos_end;
   logic [NUM_AXES-1:0][15:0] col_start;
   logic [NUM_AXES-1:0][15:0] col_end;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hor_ff <= HOR_RESET;
         ver_ff <= VER_RESET;
         far_ff <= FAR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HOR: hor_ff <= csr_data[RES_W-1:0];
            CSR_VER: ver_ff <= csr_data[RES_W-1:0];
            CSR_FAR: far_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input transfer and queue space
   assign busy   = ({1'b0, fifo_cnt} + {{CNT_W{1'b0}}, seg_valid}) >= (CNT_W+1)'(FIFO_DEPTH);
   assign accept = start && !busy;

   assign pos_start = {req_start_z, req_start_y, req_start_x};
   assign pos_end   = {req_end_z, req_end_y, req_end_x};
   assign col_start = {req_start_blue, req_start_green, req_start_red};
   assign col_end   = {req_end_blue, req_end_green, req_end_red};

   lcai_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .pos_start (pos_start),
      .pos_end   (pos_end),
      .col_start (col_start),
      .col_end   (col_end),
      .hor_res   (hor_ff),
      .ver_res   (ver_ff),
      .far_dist  (far_ff),
      .seg_valid (seg_valid),
      .seg       (seg)
   );

   lcai_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (seg_valid),
      .push_data (seg),
      .pop       (pop),
      .pop_data  (head),
      .count     (fifo_cnt)
   );

   lcai_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (fifo_cnt != '0),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_visible (rsp_visible),
      .rsp_last    (rsp_last_item),
      .rsp_point   (point)
   );

   assign rsp_point_x     = point[0];
   assign rsp_point_y     = point[1];
   assign rsp_point_z     = point[2];
   assign rsp_point_red   = point[3][15:0];
   assign rsp_point_green = point[4][15:0];
   assign rsp_point_blue  = point[5][15:0];

endmodule
